[src/ppsd_pkg.sv]
package ppsd_pkg;

    localparam int unsigned MaxVerticesDefault = 64;
    localparam int unsigned CoordW = 16;
    localparam int unsigned DistW = 34;
    localparam int unsigned DiffW = 17;
    localparam int unsigned ProdW = 34;
    localparam int unsigned DotW = 35;

    localparam logic [DistW-1:0] DistAllOnes = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_LOAD,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_START,
        S_DIV,
        S_FIN,
        S_NEXT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic best_init;
        logic load_a;
        logic load_b;
        logic mul1;
        logic mul2;
        logic sum;
        logic div_start;
        logic div_step;
        logic finish;
        logic shift_seg;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_stat;

endpackage

[src/ppsd_ram.sv]
module ppsd_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/ppsd_datapath.sv]
module ppsd_datapath (
    input  logic                                i_clk,
    input  ppsd_pkg::t_dp_cmd                   i_cmd,
    output ppsd_pkg::t_dp_stat                  o_stat,
    input  logic signed [ppsd_pkg::CoordW-1:0]  i_qx,
    input  logic signed [ppsd_pkg::CoordW-1:0]  i_qy,
    input  logic [2*ppsd_pkg::CoordW-1:0]       i_vertex,
    output logic [ppsd_pkg::DistW-1:0]          o_best
);
    import ppsd_pkg::*;

    localparam int unsigned StepW = 6;
    localparam logic [StepW-1:0] LastStep = StepW'(DistW + 1);

    logic signed [CoordW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DiffW-1:0] r_dx, r_dy, r_vx, r_vy, r_ex, r_ey;
    logic signed [ProdW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;
    logic signed [DotW-1:0] r_dot;
    logic [DistW-1:0] r_len2, r_v2, r_e2;
    logic [DistW-1:0] r_a;
    logic [DistW:0] r_b;
    logic [DistW+1:0] r_rem;
    logic [DistW-1:0] r_q;
    logic [StepW-1:0] r_step;
    logic r_sel;
    logic [DistW-1:0] r_best;
    logic [DistW-1:0] r_out;

    logic [DistW+1:0] n_r1, n_r2;
    logic [DistW-1:0] n_q1, n_q2, n_d;

    always_comb begin
        n_q1 = {r_q[DistW-2:0], 1'b0};
        n_r1 = {r_rem[DistW:0], 1'b0};
        if (n_r1 >= {2'b00, r_len2}) begin
            n_r1 = n_r1 - {2'b00, r_len2};
            n_q1 = n_q1 + 1'b1;
        end
        n_q2 = n_q1;
        n_r2 = n_r1;
        if (r_b[DistW]) begin
            n_r2 = n_r1 + {2'b00, r_a};
            if (n_r2 >= {2'b00, r_len2}) begin
                n_r2 = n_r2 - {2'b00, r_len2};
                n_q2 = n_q2 + 1'b1;
            end
        end
        n_d = r_sel ? r_e2 : r_v2;
        if (!r_sel && r_dot > 0) begin
            n_d = r_v2 - r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_ax <= i_vertex[CoordW-1:0];
            r_ay <= i_vertex[2*CoordW-1:CoordW];
        end
        if (i_cmd.load_b) begin
            r_bx <= i_vertex[CoordW-1:0];
            r_by <= i_vertex[2*CoordW-1:CoordW];
        end
        if (i_cmd.shift_seg) begin
            r_ax <= r_bx;
            r_ay <= r_by;
        end
        if (i_cmd.mul1) begin
            r_dx <= DiffW'(r_bx) - DiffW'(r_ax);
            r_dy <= DiffW'(r_by) - DiffW'(r_ay);
            r_vx <= DiffW'(i_qx) - DiffW'(r_ax);
            r_vy <= DiffW'(i_qy) - DiffW'(r_ay);
            r_ex <= DiffW'(i_qx) - DiffW'(r_bx);
            r_ey <= DiffW'(i_qy) - DiffW'(r_by);
        end
        if (i_cmd.mul2) begin
            r_p0 <= ProdW'(r_dx) * ProdW'(r_vx);
            r_p1 <= ProdW'(r_dy) * ProdW'(r_vy);
            r_p2 <= ProdW'(r_dx) * ProdW'(r_dx);
            r_p3 <= ProdW'(r_dy) * ProdW'(r_dy);
            r_p4 <= ProdW'(r_vx) * ProdW'(r_vx);
            r_p5 <= ProdW'(r_vy) * ProdW'(r_vy);
            r_p6 <= ProdW'(r_ex) * ProdW'(r_ex);
            r_p7 <= ProdW'(r_ey) * ProdW'(r_ey);
        end
        if (i_cmd.sum) begin
            r_dot  <= DotW'(r_p0) + DotW'(r_p1);
            r_len2 <= DistW'(r_p2) + DistW'(r_p3);
            r_v2   <= DistW'(r_p4) + DistW'(r_p5);
            r_e2   <= DistW'(r_p6) + DistW'(r_p7);
        end
        if (i_cmd.div_start) begin
            r_a    <= r_dot[DistW-1:0];
            r_b    <= {1'b0, r_dot[DistW-1:0]};
            r_rem  <= '0;
            r_q    <= '0;
            r_step <= '0;
            r_sel  <= (r_dot >= $signed({1'b0, r_len2}));
        end
        if (i_cmd.div_step) begin
            r_rem  <= n_r2;
            r_q    <= n_q2;
            r_b    <= {r_b[DistW-1:0], 1'b0};
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.best_init) begin
            r_best <= DistAllOnes;
        end else if (i_cmd.finish && n_d < r_best) begin
            r_best <= n_d;
        end
        if (i_cmd.out_load) begin
            r_out <= r_best;
        end
    end

    assign o_stat.div_done = (r_step == LastStep) || r_sel || (r_dot <= 0);
    assign o_best = r_out;
endmodule

[src/ppsd_ctrl.sv]
module ppsd_ctrl #(
    parameter int unsigned MaxVertices = ppsd_pkg::MaxVerticesDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_cmd,
    output logic                               o_store,
    output logic [$clog2(MaxVertices)-1:0]     o_raddr,
    output logic [$clog2(MaxVertices)-1:0]     o_waddr,
    output logic                               o_qload,
    output ppsd_pkg::t_dp_cmd                  o_dp,
    input  ppsd_pkg::t_dp_stat                 i_stat,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_no_seg
);
    import ppsd_pkg::*;

    localparam int unsigned AddrW = $clog2(MaxVertices);
    localparam int unsigned CntW = $clog2(MaxVertices + 1);
    localparam logic [CntW-1:0] Full = CntW'(MaxVertices);

    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_idx, n_idx;
    logic r_valid, n_valid, r_noseg, n_noseg;
    logic acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_noseg <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_noseg <= n_noseg;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx = r_idx;
        n_valid = r_valid;
        n_noseg = r_noseg;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_CLEAR: n_count = '0;
                        CMD_APPEND: begin
                            if (r_count != Full) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (r_count < CntW'(2)) begin
                                n_state = S_OUT;
                            end else begin
                                n_idx = '0;
                                n_state = S_RD0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                n_idx = CntW'(1);
                n_state = S_LOAD;
            end
            S_LOAD: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM: n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_idx + 1'b1 == r_count) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: n_state = S_LOAD;
            S_OUT: begin
                if (!r_valid || i_ready) begin
                    n_valid = 1'b1;
                    n_noseg = (r_count < CntW'(2));
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_dp = '0;
        o_raddr = r_idx[AddrW-1:0];
        unique case (r_state)
            S_IDLE:  o_dp.best_init = 1'b1;
            S_RD1:   o_raddr = AddrW'(1);
            S_LOAD:  o_dp.load_b = 1'b1;
            S_MUL1:  o_dp.mul1 = 1'b1;
            S_MUL2:  o_dp.mul2 = 1'b1;
            S_SUM:   o_dp.sum = 1'b1;
            S_START: o_dp.div_start = 1'b1;
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_dp.finish = 1'b1;
                end else begin
                    o_dp.div_step = 1'b1;
                end
            end
            S_FIN:   o_dp.shift_seg = 1'b1;
            S_OUT:   o_dp.out_load = !r_valid || i_ready;
            default: ;
        endcase
        if (r_state == S_RD1) begin
            o_dp.load_a = 1'b1;
        end
    end

    assign o_store = acc && (t_cmd'(i_cmd) == CMD_APPEND) && (r_count != Full);
    assign o_waddr = r_count[AddrW-1:0];
    assign o_qload = acc;
    assign o_valid = r_valid;
    assign o_no_seg = r_noseg;
endmodule

[src/polyline_point_square_distance_unit.sv]
// Point-to-polyline squared distance. Transfers with cmd 0 clear the
// polyline, cmd 1 append a vertex (ignored once MaxVertices are held), cmd 2
// query: a query returns one result, the least squared distance to any
// segment, or all ones with o_no_segment set below two vertices. A query over
// N vertices runs the 35-step restoring division for each segment whose
// projection falls inside it; a segment whose projection falls outside it
// skips the division. The result sits in an output register, so transfers
// go on while it waits; a finished query holds the input until the
// previous result has been taken.
module polyline_point_square_distance_unit #(
    parameter int unsigned MaxVertices = ppsd_pkg::MaxVerticesDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_cmd,
    input  logic signed [ppsd_pkg::CoordW-1:0] i_px,
    input  logic signed [ppsd_pkg::CoordW-1:0] i_py,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ppsd_pkg::DistW-1:0]         o_square_distance,
    output logic                               o_no_segment
);
    import ppsd_pkg::*;

    localparam int unsigned AddrW = $clog2(MaxVertices);

    logic store, qload, no_seg;
    logic [AddrW-1:0] raddr, waddr;
    logic [2*CoordW-1:0] rdata;
    t_dp_cmd dp;
    t_dp_stat st;
    logic signed [CoordW-1:0] r_qx, r_qy;
    logic [DistW-1:0] best;

    always_ff @(posedge i_clk) begin
        if (qload) begin
            r_qx <= i_px;
            r_qy <= i_py;
        end
    end

    ppsd_ram #(.Width(2*CoordW), .Depth(MaxVertices)) u_ram (
        .i_clk(i_clk), .i_we(store), .i_waddr(waddr),
        .i_wdata({i_py, i_px}), .i_raddr(raddr), .o_rdata(rdata)
    );

    ppsd_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .o_store(store), .o_raddr(raddr), .o_waddr(waddr),
        .o_qload(qload), .o_dp(dp), .i_stat(st), .o_valid(o_valid),
        .i_ready(i_ready), .o_no_seg(no_seg)
    );

    ppsd_datapath u_dp (
        .i_clk(i_clk), .i_cmd(dp), .o_stat(st), .i_qx(r_qx), .i_qy(r_qy),
        .i_vertex(rdata), .o_best(best)
    );

    assign o_square_distance = best;
    assign o_no_segment = no_seg;
endmodule
